>>> rtl/core/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Codes of the action field.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Codes of the status field.
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	// One stored entry, as it sits in the memory.
	typedef struct packed {
		logic signed [PRIO_W-1:0]  prio;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
		logic [OCC_W-1:0]          occupancy;
	} res_t;

endpackage

>>> rtl/core/spq_if.sv
interface spq_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic signed [spq_pkg::VALUE_W-1:0]  value_in;
	logic signed [spq_pkg::PRIO_W-1:0]   priority_in;

	modport source (output valid, action, value_in, priority_in, input ready);
	modport sink   (input valid, action, value_in, priority_in, output ready);
endinterface

interface spq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [spq_pkg::STATUS_W-1:0]        status;
	logic signed [spq_pkg::VALUE_W-1:0]  value_out;
	logic signed [spq_pkg::PRIO_W-1:0]   priority_out;
	logic [spq_pkg::OCC_W-1:0]           occupancy;

	modport source (output valid, status, value_out, priority_out, occupancy, input ready);
	modport sink   (input valid, status, value_out, priority_out, occupancy, output ready);
endinterface

>>> rtl/core/spq_ram.sv
module spq_ram #(
	parameter int WIDTH = spq_pkg::ENTRY_W,
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/spq_seq.sv
module spq_seq #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	spq_cmd_if.sink                   cmd,
	output logic                      res_valid,
	output spq_pkg::res_t             res,
	input  logic                      res_take,
	output logic                      ram_we,
	output logic [$clog2(DEPTH)-1:0]  ram_waddr,
	output spq_pkg::entry_t           ram_wdata,
	output logic [$clog2(DEPTH)-1:0]  ram_raddr,
	input  spq_pkg::entry_t           ram_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RD_REM = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_PLACE  = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]                          state_q;
	logic [AW-1:0]                       head_q;
	logic [CW-1:0]                       count_q;
	logic [AW-1:0]                       idx_q;
	logic signed [spq_pkg::VALUE_W-1:0]  val_q;
	logic signed [spq_pkg::PRIO_W-1:0]   pri_q;
	spq_pkg::res_t                       res_q;

	logic accept;
	logic walk_move;

	// Physical slot of a position counted from the front of the circular store.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [CW-1:0] lidx);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, lidx};
		if (sum >= (CW + 1)'(DEPTH)) begin
			sum = sum - (CW + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	// The entry just read is less urgent than the new one and moves back by one.
	assign walk_move = ram_rdata.prio > pri_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = ram_rdata;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.action == spq_pkg::ACT_INSERT) begin
					if (count_q == '0) begin
						ram_we          = 1'b1;
						ram_waddr       = head_q;
						ram_wdata.prio  = cmd.priority_in;
						ram_wdata.value = cmd.value_in;
					end else begin
						ram_raddr = phys(head_q, count_q - CW'(1));
					end
				end
			end
			S_WALK: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, CW'(idx_q) + CW'(1));
				if (walk_move) begin
					ram_wdata = ram_rdata;
					ram_raddr = phys(head_q, CW'(idx_q) - CW'(1));
				end else begin
					ram_wdata.prio  = pri_q;
					ram_wdata.value = val_q;
				end
			end
			S_PLACE: begin
				ram_we          = 1'b1;
				ram_waddr       = head_q;
				ram_wdata.prio  = pri_q;
				ram_wdata.value = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.action == spq_pkg::ACT_REMOVE) begin
							state_q <= (count_q == '0) ? S_EMIT : S_RD_REM;
						end else if (count_q == CW'(DEPTH)) begin
							state_q <= S_EMIT;
						end else if (count_q == '0) begin
							count_q <= count_q + CW'(1);
							state_q <= S_EMIT;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_RD_REM: begin
					head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
					count_q <= count_q - CW'(1);
					state_q <= S_EMIT;
				end
				S_WALK: begin
					if (!walk_move) begin
						count_q <= count_q + CW'(1);
						state_q <= S_EMIT;
					end else if (idx_q == '0) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields, walk index and result payload need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q <= cmd.value_in;
					pri_q <= cmd.priority_in;
					idx_q <= AW'(count_q - CW'(1));
					if (cmd.action == spq_pkg::ACT_REMOVE) begin
						res_q.status    <= spq_pkg::ST_EMPTY;
						res_q.value     <= '0;
						res_q.prio      <= '0;
						res_q.occupancy <= spq_pkg::OCC_W'(count_q);
					end else begin
						res_q.value <= cmd.value_in;
						res_q.prio  <= cmd.priority_in;
						if (count_q == CW'(DEPTH)) begin
							res_q.status    <= spq_pkg::ST_FULL;
							res_q.occupancy <= spq_pkg::OCC_W'(count_q);
						end else begin
							res_q.status    <= spq_pkg::ST_INSERTED;
							res_q.occupancy <= spq_pkg::OCC_W'(count_q + CW'(1));
						end
					end
				end
			end
			S_RD_REM: begin
				res_q.status    <= spq_pkg::ST_REMOVED;
				res_q.value     <= ram_rdata.value;
				res_q.prio      <= ram_rdata.prio;
				res_q.occupancy <= spq_pkg::OCC_W'(count_q - CW'(1));
			end
			S_WALK: begin
				if (walk_move) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/stable_priority_queue_top.sv
// Stable priority queue kept in sorted order; a lower priority number is more
// urgent, and entries of equal priority leave in the order they arrived.
// A transfer on the cmd channel carries an action: an insert with value_in and
// priority_in, or a remove of the front entry. Each command gives exactly one
// transfer on the rsp channel with a status (inserted, removed, empty, full),
// the value and priority of the removed entry or the echoed insert, and the
// occupancy after the command.
// The entries sit in one synchronous memory used as a circular buffer with a
// head pointer. A remove reads the head slot and advances the head. An insert
// walks from the back toward the front, one memory read and one write per
// cycle, moving every less urgent entry back by one slot. An insert into an
// empty or full store, and a remove from an empty one, go straight to the
// result without a memory read. In every case the result shows up on rsp in
// the same cycle that the next command can be taken.
// One command is worked on at a time, and the next is taken once the previous
// result has moved into the rsp output register.
// Reset clears the occupancy and head pointer; memory contents are left as is.
// When the receiver stalls rsp, the held result stays put and one further
// command may be finished and wait behind it before cmd stops taking more.
module stable_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_cmd_if.sink    cmd,
	spq_rsp_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);

	logic               res_valid;
	logic               res_take;
	spq_pkg::res_t      res;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	spq_pkg::entry_t    ram_wdata;
	spq_pkg::entry_t    ram_rdata;
	logic               out_valid_q;
	spq_pkg::res_t      out_q;

	spq_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The output register takes a new result whenever it is empty or its
	// current contents are being transferred in this cycle.
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.value_out    = out_q.value;
	assign rsp.priority_out = out_q.prio;
	assign rsp.occupancy    = out_q.occupancy;

endmodule
